// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/brt_pkg.sv =====
// ---------------------------------------------------------------------------
// brt_pkg
// Types and constants shared by the break reminder timer modules.
// ---------------------------------------------------------------------------
package brt_pkg;

  localparam logic [15:0] SEC_PER_MIN     = 16'd60;
  localparam logic [15:0] RESET_COUNTDOWN = 16'd1200;
  localparam int          CFG_IDX_W       = 3;
  localparam int          CFG_DATA_W      = 22;
  localparam int          IN_TDATA_W      = 40;
  localparam int          OUT_TDATA_W     = 32;

  typedef enum logic [1:0] {
    PH_WORK  = 2'd0,
    PH_BREAK = 2'd1,
    PH_HOLD  = 2'd2,
    PH_GRACE = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_START = 3'd1,
    EV_END   = 3'd2,
    EV_SKIP  = 3'd3,
    EV_WARN  = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_PAUSE    = 3'd1,
    REQ_SKIP     = 3'd2,
    REQ_BREAKNOW = 3'd3,
    REQ_CLAMP    = 3'd4,
    REQ_IVL_CHG  = 3'd5
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL  = 3'd0,
    CFG_BREAK     = 3'd1,
    CFG_WARN      = 3'd2,
    CFG_IDLE      = 3'd3,
    CFG_MAX_HOLD  = 3'd4,
    CFG_GRACE     = 3'd5,
    CFG_MODE      = 3'd6,
    CFG_WINDOW    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [9:0]  interval_min;
    logic [15:0] break_secs;
    logic [15:0] warn_level;
    logic [7:0]  idle_min;
    logic [7:0]  max_hold_min;
    logic [7:0]  grace_min;
    logic [8:0]  mode_bits;
    logic [21:0] work_window;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [15:0] idle_seconds;
    logic [3:0]  busy_reason;
    logic [2:0]  day_of_week;
    logic [10:0] minute_of_day;
  } item_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] countdown;
    logic [15:0] hold_count;
    logic [3:0]  reason;
    logic        paused;
  } state_t;

  typedef struct packed {
    phase_t      phase;
    logic [15:0] seconds_left;
    logic        is_paused;
    logic [3:0]  hold_reason;
    event_t      event_code;
  } result_t;

  localparam cfg_t CFG_RESET = '{
    interval_min: 10'd20,
    break_secs:   16'd20,
    warn_level:   16'd0,
    idle_min:     8'd0,
    max_hold_min: 8'd10,
    grace_min:    8'd0,
    mode_bits:    9'd0,
    work_window:  22'd0
  };

  localparam state_t STATE_RESET = '{
    phase:      PH_WORK,
    countdown:  RESET_COUNTDOWN,
    hold_count: 16'd0,
    reason:     4'd0,
    paused:     1'b0
  };

endpackage

// ===== sv/brt_cfg_regs.sv =====
// ---------------------------------------------------------------------------
// brt_cfg_regs
// Configuration register file written through the indexed write channel.
// ---------------------------------------------------------------------------
module brt_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [brt_pkg::CFG_IDX_W-1:0]   wr_index,
  input  logic [brt_pkg::CFG_DATA_W-1:0]  wr_data,
  output brt_pkg::cfg_t                   cfg
);
  import brt_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_idx_t'(wr_index))
        CFG_INTERVAL: cfg_nxt.interval_min = wr_data[9:0];
        CFG_BREAK:    cfg_nxt.break_secs   = wr_data[15:0];
        CFG_WARN:     cfg_nxt.warn_level   = wr_data[15:0];
        CFG_IDLE:     cfg_nxt.idle_min     = wr_data[7:0];
        CFG_MAX_HOLD: cfg_nxt.max_hold_min = wr_data[7:0];
        CFG_GRACE:    cfg_nxt.grace_min    = wr_data[7:0];
        CFG_MODE:     cfg_nxt.mode_bits    = wr_data[8:0];
        CFG_WINDOW:   cfg_nxt.work_window  = wr_data[21:0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/brt_step.sv =====
// ---------------------------------------------------------------------------
// brt_step
// One-item state update: tick countdown, phase changes and commands.
// ---------------------------------------------------------------------------
module brt_step (
  input  brt_pkg::cfg_t    cfg,
  input  brt_pkg::state_t  st,
  input  brt_pkg::item_t   item,
  output brt_pkg::state_t  st_nxt,
  output brt_pkg::result_t res
);
  import brt_pkg::*;

  logic [15:0] ivl_secs;
  logic [15:0] idle_lim;
  logic [15:0] hold_lim;
  logic [15:0] grace_secs;
  logic        smart;
  logic        in_hours;
  logic [2:0]  day_bit;
  logic [10:0] win_from;
  logic [10:0] win_to;
  logic        win_hit;
  logic [15:0] cd_dec;
  logic        warn_hit;
  logic [15:0] hc_inc;
  logic [3:0]  smart_busy;
  event_t      ev;
  state_t      ns;

  assign ivl_secs   = 16'({6'd0, cfg.interval_min} * SEC_PER_MIN);
  assign idle_lim   = 16'({8'd0, cfg.idle_min} * SEC_PER_MIN);
  assign hold_lim   = 16'({8'd0, cfg.max_hold_min} * SEC_PER_MIN);
  assign grace_secs = 16'({8'd0, cfg.grace_min} * SEC_PER_MIN);
  assign smart      = cfg.mode_bits[0];
  assign smart_busy = smart ? item.busy_reason : 4'd0;

  // Sunday (and the out-of-range day seven) maps to the last mask bit
  assign day_bit  = (item.day_of_week == 3'd0 || item.day_of_week == 3'd7) ? 3'd6
                  : item.day_of_week - 3'd1;
  assign win_from = cfg.work_window[10:0];
  assign win_to   = cfg.work_window[21:11];
  assign win_hit  = (win_from <= win_to)
                  ? (item.minute_of_day >= win_from && item.minute_of_day < win_to)
                  : (item.minute_of_day >= win_from || item.minute_of_day < win_to);
  assign in_hours = !cfg.mode_bits[1] || (cfg.mode_bits[4'd2 + 4'(day_bit)] && win_hit);

  assign cd_dec   = (st.countdown != 16'd0) ? st.countdown - 16'd1 : 16'd0;
  assign warn_hit = (cfg.warn_level != 16'd0) && (cd_dec == cfg.warn_level);
  assign hc_inc   = (st.hold_count != 16'hFFFF) ? st.hold_count + 16'd1 : st.hold_count;

  always_comb begin
    ns = st;
    ev = EV_NONE;
    case (req_t'(item.req_type))
      REQ_TICK: begin
        if (st.paused) begin
          ev = EV_NONE;
        end else if (st.phase == PH_BREAK) begin
          if (st.countdown <= 16'd1) begin
            ns.phase = PH_WORK; ns.countdown = ivl_secs;
            ns.hold_count = 16'd0; ns.reason = 4'd0;
            ev = EV_END;
          end else begin
            ns.countdown = st.countdown - 16'd1;
          end
        end else if (cfg.idle_min != 8'd0 && item.idle_seconds >= idle_lim) begin
          ns.phase = PH_WORK; ns.countdown = ivl_secs;
          ns.hold_count = 16'd0; ns.reason = 4'd0;
        end else if (!in_hours) begin
          ev = EV_NONE;
        end else if (st.phase == PH_WORK) begin
          if (st.countdown != 16'd0) begin
            ns.countdown = cd_dec;
            ev = warn_hit ? EV_WARN : EV_NONE;
          end else if (smart_busy != 4'd0) begin
            ns.phase = PH_HOLD; ns.hold_count = 16'd0; ns.reason = smart_busy;
          end else begin
            ns.phase = PH_BREAK; ns.countdown = cfg.break_secs;
            ns.hold_count = 16'd0; ns.reason = 4'd0;
            ev = EV_START;
          end
        end else begin
          ns.hold_count = hc_inc;
          if (hc_inc >= hold_lim) begin
            ns.phase = PH_BREAK; ns.countdown = cfg.break_secs;
            ns.hold_count = 16'd0; ns.reason = 4'd0;
            ev = EV_START;
          end else if (st.phase == PH_HOLD) begin
            ns.reason = item.busy_reason;
            if (item.busy_reason == 4'd0) begin
              if (grace_secs == 16'd0) begin
                ns.phase = PH_BREAK; ns.countdown = cfg.break_secs;
                ns.hold_count = 16'd0; ns.reason = 4'd0;
                ev = EV_START;
              end else begin
                ns.phase = PH_GRACE; ns.countdown = grace_secs;
              end
            end
          end else if (smart_busy != 4'd0) begin
            ns.phase = PH_HOLD; ns.reason = smart_busy;
          end else if (cd_dec == 16'd0) begin
            ns.phase = PH_BREAK; ns.countdown = cfg.break_secs;
            ns.hold_count = 16'd0; ns.reason = 4'd0;
            ev = EV_START;
          end else begin
            ns.reason = 4'd0; ns.countdown = cd_dec;
            ev = warn_hit ? EV_WARN : EV_NONE;
          end
        end
      end
      REQ_PAUSE: ns.paused = !st.paused;
      REQ_SKIP: begin
        ev = (st.phase == PH_BREAK) ? EV_SKIP : EV_NONE;
        ns.phase = PH_WORK; ns.countdown = ivl_secs;
        ns.hold_count = 16'd0; ns.reason = 4'd0;
      end
      REQ_BREAKNOW: begin
        ns.paused = 1'b0;
        if (st.phase != PH_BREAK) begin
          ns.phase = PH_BREAK; ns.countdown = cfg.break_secs;
          ns.hold_count = 16'd0; ns.reason = 4'd0;
          ev = EV_START;
        end
      end
      REQ_CLAMP: begin
        if (st.phase == PH_WORK && st.countdown > ivl_secs) ns.countdown = ivl_secs;
      end
      REQ_IVL_CHG: begin
        if (st.phase == PH_WORK) ns.countdown = ivl_secs;
      end
      default: ns = st;
    endcase
  end

  assign st_nxt           = ns;
  assign res.phase        = ns.phase;
  assign res.seconds_left = ns.countdown;
  assign res.is_paused    = ns.paused;
  assign res.hold_reason  = ns.reason;
  assign res.event_code   = ev;

endmodule

// ===== sv/break_reminder_timer.sv =====
// ---------------------------------------------------------------------------
// break_reminder_timer
// Break reminder with work, break, hold and grace phases, one item a cycle while results are taken.
// ---------------------------------------------------------------------------
// Usage:
//   in_*   : request items. tuser carries the request kind, tdata the idle
//            seconds, busy reason, weekday and minute of day.
//   out_*  : one result item per request: phase, seconds left, pause flag,
//            recorded busy reason and event code.
//   cfg_*  : register writes by index; always ready. Write only while idle.
// A request is held in the input register, its result in the result register.
// Throughput: one item per cycle while results are taken; the state update
//   is a single pass of logic between the input and the result register.
// A stalled receiver holds the result register; the input register then
//   fills and in_tready drops until the result is taken.
// Reset (rst_n low, synchronous): both stages empty, phase work with 1200
//   seconds, pause cleared, registers at their defaults.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module break_reminder_timer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [15:0] idle_seconds, [19:16] busy_reason, [22:20] day_of_week,
  // [33:23] minute_of_day, [39:34] zero
  input  logic [brt_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [2:0] req_type
  input  logic [2:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] phase, [17:2] seconds_left, [18] is_paused, [22:19] hold_reason,
  // [25:23] event_code, [31:26] zero
  output logic [brt_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [brt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import brt_pkg::*;

  cfg_t    cfg;
  item_t   item_r;
  logic    item_vld_r;
  state_t  st_r;
  state_t  st_nxt;
  result_t res_nxt;
  result_t res_r;
  logic    out_vld_r;
  logic    adv;

  assign cfg_ready = 1'b1;

  brt_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  brt_step u_step (
    .cfg    (cfg),
    .st     (st_r),
    .item   (item_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  assign adv       = item_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !item_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
      st_r       <= STATE_RESET;
    end else begin
      if (in_tready) item_vld_r <= in_tvalid;
      if (adv) begin
        out_vld_r <= 1'b1;
        st_r      <= st_nxt;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r.req_type      <= in_tuser;
      item_r.idle_seconds  <= in_tdata[15:0];
      item_r.busy_reason   <= in_tdata[19:16];
      item_r.day_of_week   <= in_tdata[22:20];
      item_r.minute_of_day <= in_tdata[33:23];
    end
    if (adv) res_r <= res_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, res_r.event_code, res_r.hold_reason, res_r.is_paused,
                       res_r.seconds_left, res_r.phase};

  `ASSERT_NEXT(a_res_tracks_state, adv, res_r.phase == st_r.phase && res_r.seconds_left == st_r.countdown, "result does not match updated state")
  `ASSERT_IMPLY(a_idle_phase_clear, st_r.phase == PH_WORK || st_r.phase == PH_BREAK, st_r.hold_count == 16'd0 && st_r.reason == 4'd0, "hold state left over outside hold and grace")
  `ASSERT_IMPLY(a_start_in_break, out_vld_r && res_r.event_code == EV_START, res_r.phase == PH_BREAK && !res_r.is_paused, "break start event without break phase")

endmodule

// ===== bench/tb_break_reminder_timer.sv =====
// ----------------------------------------------------------------------------
// tb_break_reminder_timer
// Self-checking bench for the break reminder timer. A queue of requests feeds
// a stream driver; every accepted request is run through a local model of the
// work/break/hold/grace timer, and the monitor compares each result item
// field by field with the oldest prediction. A directed opening is followed by
// constrained-by-hand random traffic under several register settings,
// including all-zero and all-ones, with random back-pressure on both sides and
// one long receiver stall.
// ----------------------------------------------------------------------------
module tb_break_reminder_timer;
  timeunit 1ns;
  timeprecision 1ps;
  import brt_pkg::*;

  localparam int unsigned MIN_SECS   = 60;
  localparam int unsigned LIMIT_NS   = 5_000_000;
  localparam int          DRAIN_MAX  = 20000;
  localparam logic [2:0]  REQ_SPARE6 = 3'd6;
  localparam logic [2:0]  REQ_SPARE7 = 3'd7;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [2:0]             in_tuser   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;

  break_reminder_timer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #5 clk = ~clk;

  initial begin
    #LIMIT_NS;
    $display("tb_break_reminder_timer: FAIL");
    $finish;
  end

  // timer model
  cfg_t    cf = CFG_RESET;
  state_t  st = STATE_RESET;

  item_t   request_q[$];
  item_t   on_bus;
  result_t status_q[$];

  int n_queued, n_taken, n_results, n_writes, errors;
  int in_gap_pct  = 36;
  int out_gap_pct = 36;
  int ev_seen[8];
  int ph_seen[4];

  logic [3:0]  cur_busy   = '0;
  logic [2:0]  cur_dow    = 3'd1;
  logic [10:0] cur_minute = 11'd600;

  function automatic event_t go_break();
    st.phase      = PH_BREAK;
    st.countdown  = cf.break_secs;
    st.hold_count = '0;
    st.reason     = '0;
    return EV_START;
  endfunction

  function automatic void restart_work();
    st.phase      = PH_WORK;
    st.countdown  = 16'(cf.interval_min * MIN_SECS);
    st.hold_count = '0;
    st.reason     = '0;
  endfunction

  function automatic event_t step_down();
    if (st.countdown != 0) st.countdown = st.countdown - 16'd1;
    return (cf.warn_level != 0 && st.countdown == cf.warn_level) ? EV_WARN : EV_NONE;
  endfunction

  function automatic bit in_work_hours(logic [2:0] dow, logic [10:0] minute);
    int unsigned day_bit;
    logic [10:0] win_from, win_to;
    if (!cf.mode_bits[1]) return 1'b1;
    day_bit = (dow != 0) ? dow - 1 : 6;
    if (!cf.mode_bits[2 + day_bit]) return 1'b0;
    win_from = cf.work_window[10:0];
    win_to   = cf.work_window[21:11];
    if (win_from <= win_to) return minute >= win_from && minute < win_to;
    return minute >= win_from || minute < win_to;
  endfunction

  function automatic event_t tick_update(item_t it);
    event_t ev;
    if (st.paused) return EV_NONE;
    if (st.phase == PH_BREAK) begin
      if (st.countdown <= 1) begin
        restart_work();
        return EV_END;
      end
      st.countdown = st.countdown - 16'd1;
      return EV_NONE;
    end
    if (cf.idle_min != 0 && it.idle_seconds >= cf.idle_min * MIN_SECS) begin
      restart_work();
      return EV_NONE;
    end
    if (!in_work_hours(it.day_of_week, it.minute_of_day)) return EV_NONE;
    if (st.phase == PH_WORK) begin
      if (st.countdown != 0) return step_down();
      st.reason = cf.mode_bits[0] ? it.busy_reason : 4'd0;
      if (st.reason != 0) begin
        st.phase      = PH_HOLD;
        st.hold_count = '0;
        return EV_NONE;
      end
      return go_break();
    end
    if (st.hold_count != 16'hFFFF) st.hold_count = st.hold_count + 16'd1;
    if (st.hold_count >= cf.max_hold_min * MIN_SECS) return go_break();
    if (st.phase == PH_HOLD) begin
      st.reason = it.busy_reason;
      if (st.reason == 0) begin
        st.phase     = PH_GRACE;
        st.countdown = 16'(cf.grace_min * MIN_SECS);
        if (st.countdown == 0) return go_break();
      end
      return EV_NONE;
    end
    st.reason = cf.mode_bits[0] ? it.busy_reason : 4'd0;
    if (st.reason != 0) begin
      st.phase = PH_HOLD;
      return EV_NONE;
    end
    ev = step_down();
    if (st.countdown == 0) return go_break();
    return ev;
  endfunction

  function automatic result_t timer_next(item_t it);
    result_t r;
    event_t  ev;
    ev = EV_NONE;
    case (it.req_type)
      REQ_TICK: ev = tick_update(it);
      REQ_PAUSE: st.paused = ~st.paused;
      REQ_SKIP: begin
        if (st.phase == PH_BREAK) ev = EV_SKIP;
        restart_work();
      end
      REQ_BREAKNOW: begin
        st.paused = 1'b0;
        if (st.phase != PH_BREAK) ev = go_break();
      end
      REQ_CLAMP: begin
        if (st.phase == PH_WORK && st.countdown > cf.interval_min * MIN_SECS)
          st.countdown = 16'(cf.interval_min * MIN_SECS);
      end
      REQ_IVL_CHG: begin
        if (st.phase == PH_WORK) st.countdown = 16'(cf.interval_min * MIN_SECS);
      end
      default: ;
    endcase
    r.phase        = st.phase;
    r.seconds_left = st.countdown;
    r.is_paused    = st.paused;
    r.hold_reason  = st.reason;
    r.event_code   = ev;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        status_q.push_back(timer_next(on_bus));
        n_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= in_gap_pct) begin
          on_bus = request_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {6'd0, on_bus.minute_of_day, on_bus.day_of_week,
                        on_bus.busy_reason, on_bus.idle_seconds};
          in_tuser  <= on_bus.req_type;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int stall_left;
  bit stall_done;

  always @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        n_results++;
        if (status_q.size() == 0) begin
          $error("unexpected result item %h", out_tdata);
          errors++;
        end else begin
          want = status_q.pop_front();
          check_field("phase", want.phase, out_tdata[1:0]);
          check_field("seconds_left", want.seconds_left, out_tdata[17:2]);
          check_field("is_paused", want.is_paused, out_tdata[18]);
          check_field("hold_reason", want.hold_reason, out_tdata[22:19]);
          check_field("event_code", want.event_code, out_tdata[25:23]);
          ev_seen[want.event_code]++;
          ph_seen[want.phase]++;
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if (!stall_done && n_results >= 450) begin
        stall_done = 1'b1;
        stall_left = 150;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= out_gap_pct);
      end
    end
  end

  // stimulus
  function automatic void queue_req(logic [2:0] req, logic [15:0] idle, logic [3:0] busy,
                                    logic [2:0] dow, logic [10:0] minute);
    item_t it;
    it.req_type      = req;
    it.idle_seconds  = idle;
    it.busy_reason   = busy;
    it.day_of_week   = dow;
    it.minute_of_day = minute;
    request_q.push_back(it);
    n_queued++;
  endfunction

  function automatic void queue_random(int count);
    int unsigned r;
    logic [2:0]  req;
    logic [15:0] idle;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 12)
        cur_busy = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(1, 15));
      if ($urandom_range(0, 99) < 4) cur_dow = 3'($urandom_range(0, 7));
      if ($urandom_range(0, 99) < 4)
        cur_minute = ($urandom_range(0, 15) == 0) ? 11'($urandom_range(1440, 2047))
                                                  : 11'($urandom_range(0, 1439));
      else if ($urandom_range(0, 9) == 0 && cur_minute < 11'd2047)
        cur_minute = cur_minute + 11'd1;
      r = $urandom_range(0, 99);
      if (r < 70)      idle = 16'($urandom_range(0, 30));
      else if (r < 92) idle = 16'($urandom_range(0, 1000));
      else             idle = 16'($urandom_range(0, 65535));
      r = $urandom_range(0, 99);
      if (r < 78)      req = REQ_TICK;
      else if (r < 80) req = REQ_PAUSE;
      else if (r < 85) req = REQ_SKIP;
      else if (r < 88) req = REQ_BREAKNOW;
      else if (r < 93) req = REQ_CLAMP;
      else if (r < 98) req = REQ_IVL_CHG;
      else             req = 3'($urandom_range(REQ_SPARE6, REQ_SPARE7));
      queue_req(req, idle, cur_busy, cur_dow, cur_minute);
    end
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_writes++;
    case (idx)
      CFG_INTERVAL: cf.interval_min = val[9:0];
      CFG_BREAK:    cf.break_secs   = val[15:0];
      CFG_WARN:     cf.warn_level   = val[15:0];
      CFG_IDLE:     cf.idle_min     = val[7:0];
      CFG_MAX_HOLD: cf.max_hold_min = val[7:0];
      CFG_GRACE:    cf.grace_min    = val[7:0];
      CFG_MODE:     cf.mode_bits    = val[8:0];
      CFG_WINDOW:   cf.work_window  = val[21:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(logic [9:0] iv, logic [15:0] bk, logic [15:0] wn,
                                logic [7:0] id, logic [7:0] mh, logic [7:0] gr,
                                logic [8:0] md, logic [10:0] win_end, logic [10:0] win_start);
    write_reg(CFG_INTERVAL, CFG_DATA_W'(iv));
    write_reg(CFG_BREAK,    CFG_DATA_W'(bk));
    write_reg(CFG_WARN,     CFG_DATA_W'(wn));
    write_reg(CFG_IDLE,     CFG_DATA_W'(id));
    write_reg(CFG_MAX_HOLD, CFG_DATA_W'(mh));
    write_reg(CFG_GRACE,    CFG_DATA_W'(gr));
    write_reg(CFG_MODE,     CFG_DATA_W'(md));
    write_reg(CFG_WINDOW,   {win_end, win_start});
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    while (!(n_taken == n_queued && status_q.size() == 0) && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    if (waited >= DRAIN_MAX) begin
      $error("%0d requests and %0d predictions outstanding",
             n_queued - n_taken, status_q.size());
      errors++;
    end
    repeat (4) @(posedge clk);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults
    queue_req(REQ_TICK, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_CLAMP, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_SPARE6, 16'hFFFF, 4'hF, 3'd7, 11'd2047);
    drain();

    // directed: wrapping window, smart postpone, no grace
    apply_settings(10'd0, 16'd2, 16'd1, 8'd1, 8'd1, 8'd0, 9'h1FF, 11'd60, 11'd1380);
    queue_req(REQ_IVL_CHG, 16'd0, 4'd0, 3'd1, 11'd30);
    queue_req(REQ_TICK, 16'd0, 4'd0, 3'd1, 11'd30);
    queue_req(REQ_TICK, 16'd0, 4'd0, 3'd1, 11'd30);
    queue_req(REQ_TICK, 16'd0, 4'd0, 3'd1, 11'd30);
    queue_req(REQ_TICK, 16'd0, 4'hF, 3'd0, 11'd1439);
    queue_req(REQ_TICK, 16'd0, 4'hF, 3'd3, 11'd600);
    queue_req(REQ_TICK, 16'd0, 4'hF, 3'd7, 11'd0);
    queue_req(REQ_TICK, 16'hFFFF, 4'hF, 3'd7, 11'd0);
    queue_req(REQ_PAUSE, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_TICK, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_BREAKNOW, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_BREAKNOW, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_SKIP, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_SKIP, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_CLAMP, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_SPARE6, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_SPARE7, 16'd0, 4'd0, 3'd1, 11'd0);
    queue_req(REQ_TICK, 16'd0, 4'd8, 3'd6, 11'd2047);
    queue_req(REQ_TICK, 16'd59, 4'd0, 3'd6, 11'd2047);
    queue_req(REQ_TICK, 16'd60, 4'd0, 3'd6, 11'd2047);
    queue_req(REQ_PAUSE, 16'd0, 4'd0, 3'd2, 11'd1400);
    queue_req(REQ_PAUSE, 16'd0, 4'd0, 3'd2, 11'd1400);
    queue_random(100);
    drain();

    // no idling on either side
    in_gap_pct  = 0;
    out_gap_pct = 0;
    apply_settings(10'd1, 16'd5, 16'd30, 8'd2, 8'd2, 8'd1, 9'h1FD, 11'd0, 11'd0);
    queue_random(240);
    drain();
    in_gap_pct  = 36;
    out_gap_pct = 36;

    // plain window, some days off; the long receiver stall lands here
    apply_settings(10'd2, 16'd10, 16'd100, 8'd0, 8'd3, 8'd1, 9'b101010111,
                   11'd1020, 11'd480);
    queue_random(260);
    drain();

    apply_settings(10'd0, 16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 9'd0, 11'd0, 11'd0);
    queue_random(150);
    drain();

    apply_settings(10'd1023, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 9'h1FF,
                   11'h7FF, 11'h7FF);
    queue_random(100);
    drain();

    // zero hold limit forces the break at the first hold tick
    apply_settings(10'd0, 16'd3, 16'd2, 8'd5, 8'd0, 8'd2, 9'h1FF, 11'd1380, 11'd60);
    queue_random(220);
    drain();

    apply_settings(10'd1, 16'd4, 16'd59, 8'd0, 8'd5, 8'd3, 9'h001, 11'd200, 11'd1300);
    queue_random(250);
    drain();

    $display("tb_break_reminder_timer: %0d requests, %0d results, %0d register writes",
             n_taken, n_results, n_writes);
    $display("  breaks started %0d ended %0d skipped %0d, warnings %0d, hold %0d, grace %0d",
             ev_seen[EV_START], ev_seen[EV_END], ev_seen[EV_SKIP], ev_seen[EV_WARN],
             ph_seen[PH_HOLD], ph_seen[PH_GRACE]);
    if (errors == 0) begin
      $display("tb_break_reminder_timer: PASS");
    end else begin
      $display("tb_break_reminder_timer: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/brt_pkg.sv
sv/brt_cfg_regs.sv
sv/brt_step.sv
sv/break_reminder_timer.sv
bench/tb_break_reminder_timer.sv
